// File: src/json_string_unescape_unit_defines.svh
// Assertion macros used by the port checker (jsu_checker)
`ifndef JSON_STRING_UNESCAPE_UNIT_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define JSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jsu check failed");

// Next-cycle implication, disabled during reset
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jsu check failed");

`endif

// File: src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants of the JSON string unescape unit.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    localparam logic [2:0] KIND_DATA    = 3'd1;
    localparam logic [2:0] KIND_QUOTE   = 3'd2;
    localparam logic [2:0] KIND_ENDED   = 3'd3;
    localparam logic [2:0] KIND_NOQUOTE = 3'd4;

    localparam logic [1:0] PH_SEEK = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_ESC  = 2'd2;
    localparam logic [1:0] PH_HEX  = 2'd3;

    localparam logic [9:0] LIM_RESET = 10'd63;  // capacity 64

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [9:0] written_count;
    } t_res;

    // All results of one input item, in order
    typedef struct packed {
        logic [2:0]       num;
        t_res [3:0]       ent;
    } t_bundle;

endpackage

`default_nettype wire

// File: src/jsu_if.sv
// ----------------------------------------------------------------------------
// jsu_char_if / jsu_res_if
// Valid/ready channels for input characters and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface jsu_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [9:0] written_count;
    logic       last;

    modport source (output valid, output kind, output data_byte, output written_count,
                    output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input written_count,
                    input last, output ready);
endinterface

`default_nettype wire

// File: src/json_string_unescape_unit.sv
// Latency: first result of an item is shown the cycle after the item is taken.
// Throughput: one character per cycle while results are taken unstalled; an item with
//   k results holds the output until all k are taken (k at most 4, from a \u escape plus end of string).
// Reset (synchronous, active low): parser seeks an opening quote, counts
//   clear, buffer capacity returns to 64, no result pending.
// ----------------------------------------------------------------------------
// json_string_unescape_unit
// Streaming unescaper for one JSON string literal per pass.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    jsu_char_if.sink         i_char,
    jsu_res_if.source        o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_wdata
);
    import jsu_pkg::*;

    t_bundle bundle;
    logic    can_load;
    logic    accept;

    assign i_char.ready = can_load;
    assign accept       = i_char.valid & can_load;

    jsu_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char      (i_char.char_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_bundle    (bundle)
    );

    jsu_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && bundle.num != 3'd0),
        .i_bundle   (bundle),
        .o_can_load (can_load),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire

// File: src/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Parse state and per-character decode into a bundle of results.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_char,
    input  wire logic             i_cfg_we,
    input  wire logic [10:0]      i_cfg_wdata,
    output jsu_pkg::t_bundle      o_bundle
);
    import jsu_pkg::*;

    logic [1:0]  r_phase, n_phase;
    logic [1:0]  r_hds,   n_hds;
    logic [15:0] r_cp,    n_cp;
    logic [9:0]  r_bc,    n_bc;
    logic [9:0]  r_lim;

    logic [3:0]      hex_val;
    logic [15:0]     cp_shift;
    logic [15:0]     cp_src;
    logic [1:0]      u_n;
    logic [2:0][7:0] u_b;
    logic [10:0]     bc_ext;
    logic [10:0]     lim_ext;

    logic [1:0]      d_n;
    logic [2:0][7:0] d_b;
    logic            fin;
    logic [2:0]      fin_kind;

    // Byte limit = min(capacity,1024) - 1, floored at zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= LIM_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_wdata > 11'd1024) begin
                r_lim <= 10'd1023;
            end else if (i_cfg_wdata == 11'd0) begin
                r_lim <= 10'd0;
            end else begin
                r_lim <= 10'(i_cfg_wdata - 11'd1);
            end
        end
    end

    always_comb begin
        case (i_char) inside
            [8'h30:8'h39]: hex_val = 4'(i_char - 8'h30);
            [8'h61:8'h66]: hex_val = 4'(i_char - 8'h57);
            [8'h41:8'h46]: hex_val = 4'(i_char - 8'h37);
            default:       hex_val = 4'd0;
        endcase
    end

    assign cp_shift = {r_cp[11:0], hex_val};
    // On NUL the digits seen so far form the code point
    assign cp_src   = (i_char == 8'd0) ? r_cp : cp_shift;
    assign bc_ext   = {1'b0, r_bc};
    assign lim_ext  = {1'b0, r_lim};

    // UTF-8 encode of cp_src, dropped whole when it does not fit
    always_comb begin
        u_n = 2'd0;
        u_b = '0;
        if (cp_src < 16'h0080 && bc_ext + 11'd1 <= lim_ext) begin
            u_n    = 2'd1;
            u_b[0] = cp_src[7:0];
        end else if (cp_src < 16'h0800 && bc_ext + 11'd2 <= lim_ext) begin
            u_n    = 2'd2;
            u_b[0] = 8'hC0 | {3'b000, cp_src[10:6]};
            u_b[1] = 8'h80 | {2'b00, cp_src[5:0]};
        end else if (bc_ext + 11'd3 <= lim_ext) begin
            u_n    = 2'd3;
            u_b[0] = 8'hE0 | {4'b0000, cp_src[15:12]};
            u_b[1] = 8'h80 | {2'b00, cp_src[11:6]};
            u_b[2] = 8'h80 | {2'b00, cp_src[5:0]};
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_hds    = r_hds;
        n_cp     = r_cp;
        n_bc     = r_bc;
        d_n      = 2'd0;
        d_b      = '0;
        fin      = 1'b0;
        fin_kind = KIND_ENDED;
        case (r_phase)
            PH_BODY: begin
                if (i_char == 8'd0) begin
                    fin = 1'b1;
                end else if (i_char == 8'h22) begin
                    fin      = 1'b1;
                    fin_kind = KIND_QUOTE;
                end else if (r_bc >= r_lim) begin
                    fin = 1'b1;
                end else if (i_char == 8'h5C) begin
                    n_phase = PH_ESC;
                end else begin
                    d_n    = 2'd1;
                    d_b[0] = i_char;
                end
            end
            PH_ESC: begin
                if (i_char == 8'd0) begin
                    fin = 1'b1;
                end else if (i_char == 8'h75) begin
                    n_phase = PH_HEX;
                    n_hds   = 2'd0;
                    n_cp    = 16'd0;
                end else begin
                    n_phase = PH_BODY;
                    d_n     = 2'd1;
                    case (i_char)
                        8'h6E:   d_b[0] = 8'd10;
                        8'h74:   d_b[0] = 8'd9;
                        8'h72:   d_b[0] = 8'd13;
                        default: d_b[0] = i_char;
                    endcase
                end
            end
            PH_HEX: begin
                if (i_char == 8'd0) begin
                    d_n = u_n;
                    d_b = u_b;
                    fin = 1'b1;
                end else if (r_hds == 2'd3) begin
                    d_n     = u_n;
                    d_b     = u_b;
                    n_hds   = 2'd0;
                    n_cp    = 16'd0;
                    n_phase = PH_BODY;
                end else begin
                    n_cp  = cp_shift;
                    n_hds = r_hds + 2'd1;
                end
            end
            default: begin
                n_phase = PH_SEEK;
                if (i_char == 8'h20 || i_char == 8'h0A || i_char == 8'h0D
                        || i_char == 8'h09) begin
                    n_phase = PH_SEEK;
                end else if (i_char == 8'h22) begin
                    n_phase = PH_BODY;
                    n_bc    = 10'd0;
                end else begin
                    n_bc     = 10'd0;
                    fin      = 1'b1;
                    fin_kind = KIND_NOQUOTE;
                end
            end
        endcase

        if (!fin) begin
            n_bc = r_bc + 10'(d_n);
        end else begin
            n_phase = PH_SEEK;
            n_bc    = 10'd0;
            n_hds   = 2'd0;
            n_cp    = 16'd0;
        end
    end

    // Bundle: data bytes first, then the closing result if any
    always_comb begin
        o_bundle.num = {1'b0, d_n} + {2'b00, fin};
        for (int k = 0; k < 4; k++) begin
            o_bundle.ent[k].kind          = KIND_DATA;
            o_bundle.ent[k].data_byte     = (k < 3) ? d_b[k[1:0]] : 8'd0;
            o_bundle.ent[k].written_count = r_bc + 10'(k + 1);
            if (fin && k[1:0] == d_n) begin
                o_bundle.ent[k].kind          = fin_kind;
                o_bundle.ent[k].data_byte     = 8'd0;
                o_bundle.ent[k].written_count =
                    (fin_kind == KIND_NOQUOTE) ? 10'd0 : r_bc + 10'(d_n);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_hds   <= 2'd0;
            r_cp    <= 16'd0;
            r_bc    <= 10'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_hds   <= n_hds;
            r_cp    <= n_cp;
            r_bc    <= n_bc;
        end
    end

endmodule

`default_nettype wire

// File: src/jsu_emit.sv
// ----------------------------------------------------------------------------
// jsu_emit
// Result register: holds one item's results and hands them out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_emit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  jsu_pkg::t_bundle      i_bundle,
    output logic                  o_can_load,
    jsu_res_if.source             o_res
);
    import jsu_pkg::*;

    logic [2:0]       r_left;
    logic [1:0]       r_pos;
    logic [3:0][20:0] r_ent;
    t_res             cur;
    logic             fire;

    assign cur                 = t_res'(r_ent[r_pos]);
    assign fire                = o_res.valid & o_res.ready;
    assign o_res.valid         = (r_left != 3'd0);
    assign o_res.last          = (r_left == 3'd1);
    assign o_res.kind          = cur.kind;
    assign o_res.data_byte     = cur.data_byte;
    assign o_res.written_count = cur.written_count;

    // Free now, or the final result leaves this cycle
    assign o_can_load = (r_left == 3'd0) || (r_left == 3'd1 && o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_pos  <= 2'd0;
        end else if (i_load) begin
            r_left <= i_bundle.num;
            r_pos  <= 2'd0;
        end else if (fire) begin
            r_left <= r_left - 3'd1;
            r_pos  <= r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < 4; k++) begin
                r_ent[k] <= i_bundle.ent[k];
            end
        end
    end

endmodule

`default_nettype wire

// File: src/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the result channel of the unescape unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "json_string_unescape_unit_defines.svh"

module jsu_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       i_ready,
    input wire logic [2:0] i_kind,
    input wire logic [7:0] i_data_byte,
    input wire logic [9:0] i_written_count,
    input wire logic       i_last
);
    import jsu_pkg::*;

    // A closing or error result always ends its item
    `JSU_ASSERT_NOW(a_close_is_last, i_clk, i_rst_n, i_valid && i_kind != KIND_DATA, i_last)
    // Missing opening quote carries no byte and no count
    `JSU_ASSERT_NOW(a_noquote_empty, i_clk, i_rst_n, i_valid && i_kind == KIND_NOQUOTE,
        i_written_count == 10'd0 && i_data_byte == 8'd0)
    // Remaining results of an item follow without a gap
    `JSU_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, i_valid && i_ready && !i_last, i_valid)
    `JSU_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid)

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_kind          (o_res.kind),
    .i_data_byte     (o_res.data_byte),
    .i_written_count (o_res.written_count),
    .i_last          (o_res.last)
);

`default_nettype wire

// File: dv/jsu_unescape_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jsu_unescape_checker
// Watches the character and result channels of the unescape unit. It tracks
// the parser state for every accepted character, queues the decoded bytes
// and end markers that follow, and compares each accepted result with them.
// ----------------------------------------------------------------------------

module jsu_unescape_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_char_valid,
    input  wire logic        i_char_ready,
    input  wire logic [7:0]  i_char,
    input  wire logic        i_res_valid,
    input  wire logic        i_res_ready,
    input  wire logic [2:0]  i_res_kind,
    input  wire logic [7:0]  i_res_byte,
    input  wire logic [9:0]  i_res_count,
    input  wire logic        i_res_last,
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam int         REPORT_MAX   = 10;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [9:0] written_count;
        logic       last;
    } t_decoded;

    t_decoded    decoded_q[$];
    t_decoded    item_res[4];
    int unsigned item_n;
    int          fails;

    logic [10:0] capacity;
    logic [1:0]  phase;
    logic [1:0]  hex_seen;
    logic [15:0] code_point;
    logic [9:0]  byte_count;

    // Bytes that fit: capacity less the terminator, capacity clamped to 1024
    function automatic int fill_limit(input logic [10:0] cap);
        int c;
        c = (cap > 11'd1024) ? 1024 : int'(cap);
        return (c == 0) ? 0 : c - 1;
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
        if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
        return 4'd0;
    endfunction

    task automatic add_result(input logic [2:0] kind, input logic [7:0] data);
        item_res[item_n] = '{kind: kind, data_byte: data, written_count: byte_count,
                             last: 1'b0};
        item_n++;
    endtask

    task automatic emit_byte(input logic [7:0] data);
        byte_count = byte_count + 10'd1;
        add_result(KIND_DATA, data);
    endtask

    task automatic end_string(input logic [2:0] kind);
        add_result(kind, 8'h00);
        phase      = PH_SEEK;
        byte_count = '0;
        hex_seen   = '0;
        code_point = '0;
    endtask

    // UTF-8 of the code point, dropped whole if it does not fit
    task automatic emit_code_point();
        int lim;
        int used;
        lim  = fill_limit(capacity);
        used = int'(byte_count);
        if (code_point < 16'h0080 && used + 1 <= lim) begin
            emit_byte(code_point[7:0]);
        end else if (code_point < 16'h0800 && used + 2 <= lim) begin
            emit_byte(8'hC0 | {3'b000, code_point[10:6]});
            emit_byte(8'h80 | {2'b00, code_point[5:0]});
        end else if (used + 3 <= lim) begin
            emit_byte(8'hE0 | {4'h0, code_point[15:12]});
            emit_byte(8'h80 | {2'b00, code_point[11:6]});
            emit_byte(8'h80 | {2'b00, code_point[5:0]});
        end
    endtask

    task automatic decode_char(input logic [7:0] c);
        logic [7:0] mapped;
        item_n = 0;
        case (phase)
            PH_BODY: begin
                if (c == CH_NUL) begin
                    end_string(KIND_ENDED);
                end else if (c == CH_QUOTE) begin
                    end_string(KIND_QUOTE);
                end else if (int'(byte_count) >= fill_limit(capacity)) begin
                    end_string(KIND_ENDED);
                end else if (c == CH_BACKSLASH) begin
                    phase = PH_ESC;
                end else begin
                    emit_byte(c);
                end
            end
            PH_ESC: begin
                if (c == CH_NUL) begin
                    end_string(KIND_ENDED);
                end else if (c == CH_U) begin
                    phase      = PH_HEX;
                    hex_seen   = '0;
                    code_point = '0;
                end else begin
                    mapped = c;
                    if (c == CH_N) mapped = CH_LF;
                    else if (c == CH_T) mapped = CH_TAB;
                    else if (c == CH_R) mapped = CH_CR;
                    phase = PH_BODY;
                    emit_byte(mapped);
                end
            end
            PH_HEX: begin
                if (c == CH_NUL) begin
                    // partial escape still flushes what was gathered
                    emit_code_point();
                    end_string(KIND_ENDED);
                end else begin
                    code_point = {code_point[11:0], hex_nibble(c)};
                    if (hex_seen == 2'd3) begin
                        hex_seen = '0;
                        phase    = PH_BODY;
                        emit_code_point();
                        code_point = '0;
                    end else begin
                        hex_seen = hex_seen + 2'd1;
                    end
                end
            end
            default: begin
                phase = PH_SEEK;
                if (c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB) begin
                end else if (c == CH_QUOTE) begin
                    phase      = PH_BODY;
                    byte_count = '0;
                end else begin
                    byte_count = '0;
                    add_result(KIND_NOQUOTE, 8'h00);
                end
            end
        endcase
        for (int i = 0; i < int'(item_n); i++) begin
            item_res[i].last = (i == int'(item_n) - 1);
            decoded_q.push_back(item_res[i]);
        end
    endtask

    task automatic check_result();
        t_decoded got;
        t_decoded want;
        got = '{kind: i_res_kind, data_byte: i_res_byte, written_count: i_res_count,
                last: i_res_last};
        if (decoded_q.size() == 0) begin
            fails++;
            if (fails <= REPORT_MAX)
                $display("%0t: unexpected result kind %0d byte %02h count %0d last %0b",
                         $realtime, got.kind, got.data_byte, got.written_count, got.last);
        end else begin
            want = decoded_q.pop_front();
            if (got !== want) begin
                fails++;
                if (fails <= REPORT_MAX)
                    $display("%0t: mismatch exp k%0d b%02h c%0d l%0b got k%0d b%02h c%0d l%0b",
                             $realtime, want.kind, want.data_byte, want.written_count,
                             want.last, got.kind, got.data_byte, got.written_count, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity   = 11'd64;
            phase      = PH_SEEK;
            hex_seen   = '0;
            code_point = '0;
            byte_count = '0;
            fails      = 0;
            decoded_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) check_result();
            if (i_cfg_we) capacity = i_cfg_wdata;
            if (i_char_valid && i_char_ready) decode_char(i_char);
        end
        o_pending    <= decoded_q.size();
        o_fail_count <= fails;
    end

endmodule

// File: dv/tb_json_string_unescape_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_unit
// Drives character streams into the unescape unit: a directed opening, then
// random strings with escapes, unicode escapes and broken endings over a
// range of buffer capacities, with random idling on both channels.
// ----------------------------------------------------------------------------

module tb_json_string_unescape_unit;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 28;
    localparam int FINAL_ITEMS   = 60;
    localparam int FILL_CAPACITY = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [10:0] cfg_wdata;
    logic        idle_on;
    int          stall_left;
    int          items_sent;
    int          cycles;
    int          fail_count;
    int          pending;

    jsu_char_if char_ch ();
    jsu_res_if  res_ch ();

    json_string_unescape_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (char_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    jsu_unescape_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_valid (char_ch.valid),
        .i_char_ready (char_ch.ready),
        .i_char       (char_ch.char_in),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_res_kind   (res_ch.kind),
        .i_res_byte   (res_ch.data_byte),
        .i_res_count  (res_ch.written_count),
        .i_res_last   (res_ch.last),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side back-pressure in bursts of random length
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left   <= $urandom_range(0, 5);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Called just after a rising edge; returns just after the item is taken
    task automatic send_char(input logic [7:0] c);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            char_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        char_ch.valid   <= 1'b1;
        char_ch.char_in <= c;
        @(posedge i_clk);
        while (!char_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == "\"" || c == "\\");
        return c;
    endfunction

    function automatic logic [7:0] space_char();
        string spaces;
        spaces = " \t\r\n";
        return spaces[$urandom_range(0, 3)];
    endfunction

    function automatic logic [7:0] escaped_char();
        string named;
        named = "ntr\"\\/bf";
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(1, 255));
        return named[$urandom_range(0, named.len() - 1)];
    endfunction

    function automatic logic [7:0] hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(1, 255));
        return digits[$urandom_range(0, digits.len() - 1)];
    endfunction

    task automatic send_unicode_escape(input int digits);
        send_text("\\u");
        repeat (digits) send_char(hex_char());
    endtask

    // One string literal with random body; broken ones lack the opening quote, end early or stay open
    task automatic send_string(input bit well_formed);
        int len;
        int pick;
        repeat ($urandom_range(0, 2)) send_char(space_char());
        if (!well_formed && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
        end else begin
            send_char("\"");
            len = $urandom_range(0, 10);
            repeat (len) begin
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    send_char(plain_char());
                end else if (pick < 8) begin
                    send_char("\\");
                    send_char(escaped_char());
                end else begin
                    send_unicode_escape(4);
                end
            end
            if (well_formed) begin
                send_char("\"");
            end else begin
                case ($urandom_range(0, 3))
                    0: send_char(8'h00);
                    1: begin
                        send_char("\\");
                        send_char(8'h00);
                    end
                    2: begin
                        send_unicode_escape($urandom_range(0, 3));
                        send_char(8'h00);
                    end
                    default: ;  // left open; the next string runs on into it
                endcase
            end
        end
    endtask

    task automatic send_strings_until(input int target);
        while (items_sent < target) send_string($urandom_range(0, 4) != 0);
    endtask

    task automatic wait_results_done();
        char_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [10:0] cap);
        wait_results_done();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [10:0] caps[7];
        char_ch.valid   = 1'b0;
        char_ch.char_in = 8'h00;
        res_ch.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        i_rst_n         = 1'b0;
        idle_on         = 1'b1;
        stall_left      = 0;
        items_sent      = 0;
        cycles          = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: whitespace, stray chars, escapes, unicode, early ends
        send_text(" \t\r\nx");
        send_char(8'h00);
        send_text("\"A");
        send_char(8'hFF);
        send_text("\\n\\q\\u07Ff\\u0041\\uFFFF\"");
        send_text("\"\\");
        send_char(8'h00);
        send_text("\"\\uFg");
        send_char(8'h00);

        caps = '{11'd1, 11'd2, 11'd3, 11'd5, 11'd1023, 11'd8,
                 11'($urandom_range(1, 2047))};
        foreach (caps[i]) begin
            write_capacity(caps[i]);
            idle_on <= (i != 3);
            send_strings_until(items_sent + PHASE_ITEMS);
        end

        // small buffer: fill it completely, then the next char ends it
        write_capacity(11'(FILL_CAPACITY));
        idle_on <= 1'b1;
        send_char("\"");
        repeat (FILL_CAPACITY - 1) send_char(plain_char());
        send_char("z");
        send_strings_until(items_sent + PHASE_ITEMS);

        write_capacity(11'($urandom_range(4, 64)));
        idle_on = 1'b0;
        send_strings_until(items_sent + FINAL_ITEMS);

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
